@@ sv/csvt_pkg.sv @@
// Package with the shared types, constants and register codes of the CSV field tokenizer.
package csvt_pkg;

	// Parameter defaults.
	localparam int DEFAULT_FIELD_CAPACITY = 1024;
	localparam int DEFAULT_MAX_COLUMNS    = 256;
	localparam int DEFAULT_MAX_RECORDS    = 65536;

	// Field widths.
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 10;
	localparam int COL_W    = 9;
	localparam int REC_W    = 16;
	localparam int CFG_IX_W = 2;
	localparam int CFG_D_W  = 10;

	// Configuration register indexes.
	localparam logic [CFG_IX_W-1:0] REG_DELIMITER = 2'd0;
	localparam logic [CFG_IX_W-1:0] REG_QUOTE     = 2'd1;
	localparam logic [CFG_IX_W-1:0] REG_NEWLINE   = 2'd2;
	localparam logic [CFG_IX_W-1:0] REG_MAX_LEN   = 2'd3;

	// Configuration reset values.
	localparam logic [BYTE_W-1:0] RST_DELIMITER = 8'd44;
	localparam logic [BYTE_W-1:0] RST_QUOTE     = 8'd34;
	localparam logic [BYTE_W-1:0] RST_NEWLINE   = 8'd10;
	localparam logic [LEN_W-1:0]  RST_MAX_LEN   = 10'd255;

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_QUOTED = 2'd1,
		MODE_AFTER  = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [LEN_W-1:0]   stored_length;
		logic [COL_W-1:0]   field_counter;
		logic [REC_W-1:0]   record_counter;
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  delimiter_char;
		logic [BYTE_W-1:0]  quote_char;
		logic [BYTE_W-1:0]  newline_char;
		logic [LEN_W-1:0]   max_field_len;
	} cfg_t;

	typedef struct packed {
		logic               emit;
		logic               byte_valid;
		logic [BYTE_W-1:0]  out_byte;
		logic               field_end;
		logic               record_end;
		logic [LEN_W-1:0]   field_length;
		logic [COL_W-1:0]   column_count;
		logic [REC_W-1:0]   record_index;
	} result_t;

endpackage

@@ sv/csv_field_tokenizer.sv @@
// Top level of the streaming CSV field tokenizer with its result register and config port.
// The tokenizer takes one CSV byte, or an end-of-input mark, per input beat and turns the
// stream into field content bytes, field ends and record ends, in the RFC 4180 style:
// quoted content, doubled quotes collapsed to one, delimiter and newline bytes that are
// configurable, and a field length limit beyond which content bytes are dropped. Each
// input beat yields at most one result beat; beats that only change the quoting mode,
// dropped bytes and an end-of-input mark with nothing pending give none. The block takes
// one input beat per cycle unless a held result stalls it: all of the work is done by the
// decode logic between the tokenizer state and the single result register, and a new
// beat is accepted whenever that register is empty or is being drained in the same cycle.
// Configuration is written through its own channel, which is always ready, and should be
// written only while the block is idle.
module csv_field_tokenizer #(
	parameter int FIELD_CAPACITY = csvt_pkg::DEFAULT_FIELD_CAPACITY,
	parameter int MAX_COLUMNS    = csvt_pkg::DEFAULT_MAX_COLUMNS,
	parameter int MAX_RECORDS    = csvt_pkg::DEFAULT_MAX_RECORDS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [csvt_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic [csvt_pkg::CFG_D_W-1:0]  cfg_data,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [csvt_pkg::BYTE_W-1:0]   data_byte,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          byte_valid,
	output logic [csvt_pkg::BYTE_W-1:0]   out_byte,
	output logic                          field_end,
	output logic                          record_end,
	output logic [csvt_pkg::LEN_W-1:0]    field_length,
	output logic [csvt_pkg::COL_W-1:0]    column_count,
	output logic [csvt_pkg::REC_W-1:0]    record_index
);
	import csvt_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    in_acc;

	// The configuration registers never stall a write.
	assign cfg_ready = 1'b1;

	// A new beat enters when the result register is free or empties in this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	csvt_step #(
		.FIELD_CAPACITY (FIELD_CAPACITY),
		.MAX_COLUMNS    (MAX_COLUMNS),
		.MAX_RECORDS    (MAX_RECORDS)
	) u_step (
		.cur       (state_q),
		.cfg       (cfg_q),
		.kind      (kind),
		.data_byte (data_byte),
		.nxt       (state_nxt),
		.res       (res)
	);

	// Configuration registers. Index codes outside the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_char <= RST_DELIMITER;
			cfg_q.quote_char     <= RST_QUOTE;
			cfg_q.newline_char   <= RST_NEWLINE;
			cfg_q.max_field_len  <= RST_MAX_LEN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELIMITER: cfg_q.delimiter_char <= cfg_data[BYTE_W-1:0];
				REG_QUOTE:     cfg_q.quote_char     <= cfg_data[BYTE_W-1:0];
				REG_NEWLINE:   cfg_q.newline_char   <= cfg_data[BYTE_W-1:0];
				REG_MAX_LEN:   cfg_q.max_field_len  <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Tokenizer state and the result-register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode           <= MODE_PLAIN;
			state_q.stored_length  <= '0;
			state_q.field_counter  <= '0;
			state_q.record_counter <= '0;
			out_valid_q            <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q     <= state_nxt;
				out_valid_q <= res.emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; it loads only when an accepted beat yields a result.
	always_ff @(posedge clk) begin
		if (in_acc && res.emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_valid   = res_q.byte_valid;
	assign out_byte     = res_q.out_byte;
	assign field_end    = res_q.field_end;
	assign record_end   = res_q.record_end;
	assign field_length = res_q.field_length;
	assign column_count = res_q.column_count;
	assign record_index = res_q.record_index;

`ifndef SYNTHESIS
	// A result carries either a content byte or a field end, never both.
	a_byte_xor_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.byte_valid && res_q.field_end))
		else $error("content byte and field end in one result");

	// Every record end also closes a field.
	a_record_has_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.record_end |-> res_q.field_end)
		else $error("record end without field end");

	// End of input leaves the tokenizer in plain mode with the field state cleared.
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && kind |=> state_q.mode == MODE_PLAIN && state_q.stored_length == '0
			&& state_q.field_counter == '0)
		else $error("end of input did not clear the field state");

	// A held result blocks new input.
	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !in_ready)
		else $error("input accepted while a result is held");

	// The record counter only moves on a completed record.
	a_record_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && res.record_end) |=> $stable(state_q.record_counter))
		else $error("record counter changed without a record end");
`endif

endmodule

@@ sv/csvt_step.sv @@
// Combinational next-state and result logic for one input beat of the CSV tokenizer.
module csvt_step #(
	parameter int FIELD_CAPACITY = csvt_pkg::DEFAULT_FIELD_CAPACITY,
	parameter int MAX_COLUMNS    = csvt_pkg::DEFAULT_MAX_COLUMNS,
	parameter int MAX_RECORDS    = csvt_pkg::DEFAULT_MAX_RECORDS
) (
	input  csvt_pkg::state_t  cur,
	input  csvt_pkg::cfg_t    cfg,
	input  logic              kind,
	input  logic [7:0]        data_byte,
	output csvt_pkg::state_t  nxt,
	output csvt_pkg::result_t res
);
	import csvt_pkg::*;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_PUSH,
		ACT_FIELD,
		ACT_RECORD
	} act_t;

	localparam logic [16:0] CAP_LIMIT = 17'(FIELD_CAPACITY - 1);
	localparam logic [16:0] COL_LIM   = 17'(MAX_COLUMNS);
	localparam logic [24:0] REC_LIM   = 25'(MAX_RECORDS);

	act_t        act;
	mode_t       mode_after;
	logic [16:0] limit;
	logic        full;
	logic        col_inc_ok;
	logic        rec_inc_ok;
	logic        is_delim;
	logic        is_quote;
	logic        is_nl;

	assign is_delim   = (data_byte == cfg.delimiter_char);
	assign is_quote   = (data_byte == cfg.quote_char);
	assign is_nl      = (data_byte == cfg.newline_char);
	assign limit      = (17'(cfg.max_field_len) > CAP_LIMIT) ? CAP_LIMIT
	                                                        : 17'(cfg.max_field_len);
	assign full       = (17'(cur.stored_length) >= limit);
	assign col_inc_ok = ((17'(cur.field_counter) + 17'd1) < COL_LIM);
	assign rec_inc_ok = ((25'(cur.record_counter) + 25'd1) < REC_LIM);

	// Pick the action and the mode that follows from the byte class.
	always_comb begin
		act        = ACT_NONE;
		mode_after = cur.mode;
		if (kind) begin
			mode_after = MODE_PLAIN;
			if (cur.stored_length != '0 || cur.field_counter != '0) begin
				act = ACT_RECORD;
			end
		end else if (cur.mode == MODE_QUOTED) begin
			if (is_quote) begin
				mode_after = MODE_AFTER;
			end else begin
				act = ACT_PUSH;
			end
		end else if (cur.mode == MODE_AFTER && is_quote) begin
			mode_after = MODE_QUOTED;
			act        = ACT_PUSH;
		end else begin
			// Plain handling, also for a byte that follows a closing quote.
			mode_after = MODE_PLAIN;
			if (is_delim) begin
				act = ACT_FIELD;
			end else if (is_quote) begin
				mode_after = MODE_QUOTED;
			end else if (is_nl) begin
				act = ACT_RECORD;
			end else begin
				act = ACT_PUSH;
			end
		end
	end

	always_comb begin
		nxt              = cur;
		nxt.mode         = mode_after;
		res              = '0;
		res.record_index = cur.record_counter;
		unique case (act)
			ACT_PUSH: begin
				if (!full) begin
					nxt.stored_length = cur.stored_length + LEN_W'(1);
					res.emit          = 1'b1;
					res.byte_valid    = 1'b1;
					res.out_byte      = data_byte;
				end
			end
			ACT_FIELD: begin
				res.emit          = 1'b1;
				res.field_end     = 1'b1;
				res.field_length  = cur.stored_length;
				nxt.stored_length = '0;
				if (col_inc_ok) begin
					nxt.field_counter = cur.field_counter + COL_W'(1);
				end
			end
			ACT_RECORD: begin
				res.emit          = 1'b1;
				res.field_end     = 1'b1;
				res.record_end    = 1'b1;
				res.field_length  = cur.stored_length;
				res.column_count  = cur.field_counter + COL_W'(1);
				nxt.stored_length = '0;
				nxt.field_counter = '0;
				if (rec_inc_ok) begin
					nxt.record_counter = cur.record_counter + REC_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (kind) begin
			nxt.stored_length = '0;
			nxt.field_counter = '0;
		end
	end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the CSV field tokenizer, with a token predictor and random traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import csvt_pkg::*;

	// The block is built with its default sizes, so the predictor uses the same ones.
	localparam int FIELD_CAPACITY = DEFAULT_FIELD_CAPACITY;
	localparam int MAX_COLUMNS    = DEFAULT_MAX_COLUMNS;
	localparam int MAX_RECORDS    = DEFAULT_MAX_RECORDS;

	// Longest stretch without any accepted beat that a correct run can show comes from a long
	// sender gap, a long receiver stall or the settle pause, well short of this limit.
	localparam int QUIET_LIMIT = 2000;

	// One result beat as the block presents it.
	typedef struct packed {
		logic              byte_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              field_end;
		logic              record_end;
		logic [LEN_W-1:0]  field_length;
		logic [COL_W-1:0]  column_count;
		logic [REC_W-1:0]  record_index;
	} token_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IX_W-1:0] cfg_index = '0;
	logic [CFG_D_W-1:0]  cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic                kind      = 1'b0;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                byte_valid;
	logic [BYTE_W-1:0]   out_byte;
	logic                field_end;
	logic                record_end;
	logic [LEN_W-1:0]    field_length;
	logic [COL_W-1:0]    column_count;
	logic [REC_W-1:0]    record_index;

	csv_field_tokenizer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_valid   (byte_valid),
		.out_byte     (out_byte),
		.field_end    (field_end),
		.record_end   (record_end),
		.field_length (field_length),
		.column_count (column_count),
		.record_index (record_index)
	);

	initial begin : clock_gen
		forever #4 clk = ~clk;
	end

	// Input beats waiting to be driven, each one {kind, data_byte}, and the tokens that
	// the accepted beats are expected to produce, oldest first.
	logic [8:0]  beats_to_send[$];
	token_t      tokens_due[$];
	int unsigned errors       = 0;
	int unsigned quiet_cycles = 0;

	// Handshakes seen at the last rising edge, so that the falling-edge drivers know
	// whether their beat has gone.
	bit in_taken  = 1'b0;
	bit cfg_taken = 1'b0;

	// When set, neither side idles: the sender streams back to back and the receiver
	// never stalls.
	bit calm = 1'b0;

	int unsigned send_gap   = 0;
	int unsigned stall_left = 0;

	// Predictor copy of the configuration registers, reset values to start with.
	logic [BYTE_W-1:0] cfg_delim   = RST_DELIMITER;
	logic [BYTE_W-1:0] cfg_quote   = RST_QUOTE;
	logic [BYTE_W-1:0] cfg_newline = RST_NEWLINE;
	logic [LEN_W-1:0]  cfg_max_len = RST_MAX_LEN;

	// Predictor copy of the tokenizer state.
	mode_t             tok_mode = MODE_PLAIN;
	logic [LEN_W-1:0]  tok_len  = '0;
	logic [COL_W-1:0]  tok_cols = '0;
	logic [REC_W-1:0]  tok_rec  = '0;

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int unsigned idle_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Closes the current field, and the record as well when last is set. The record
	// index reported is the one before this close, and both counters saturate.
	function automatic token_t close_field(input logic last);
		token_t t;
		t              = '0;
		t.field_end    = 1'b1;
		t.record_end   = last;
		t.field_length = tok_len;
		t.record_index = tok_rec;
		if (last) begin
			t.column_count = tok_cols + 1'b1;
			tok_cols       = '0;
			if (int'(tok_rec) + 1 < MAX_RECORDS)
				tok_rec = tok_rec + 1'b1;
		end else if (int'(tok_cols) + 1 < MAX_COLUMNS) begin
			tok_cols = tok_cols + 1'b1;
		end
		tok_len = '0;
		return t;
	endfunction

	// A content byte is passed on only while the field has room left under the limit.
	function automatic bit keep_byte(input logic [BYTE_W-1:0] b, output token_t t);
		int limit;
		t     = '0;
		limit = (int'(cfg_max_len) > FIELD_CAPACITY - 1) ? FIELD_CAPACITY - 1
			: int'(cfg_max_len);
		if (int'(tok_len) >= limit)
			return 1'b0;
		tok_len        = tok_len + 1'b1;
		t.byte_valid   = 1'b1;
		t.out_byte     = b;
		t.record_index = tok_rec;
		return 1'b1;
	endfunction

	// Steps the predicted tokenizer by one input beat. Returns whether a result beat is
	// due, and the token in t.
	function automatic bit tokenize(input logic is_end, input logic [BYTE_W-1:0] b,
		output token_t t);
		bit hit;
		t   = '0;
		hit = 1'b0;
		if (is_end) begin
			// End of input flushes whatever is pending, even inside an open quote.
			if (tok_len != '0 || tok_cols != '0) begin
				t   = close_field(1'b1);
				hit = 1'b1;
			end
			tok_mode = MODE_PLAIN;
			tok_len  = '0;
			tok_cols = '0;
			return hit;
		end
		if (tok_mode == MODE_QUOTED) begin
			if (b == cfg_quote) begin
				tok_mode = MODE_AFTER;
				return 1'b0;
			end
			return keep_byte(b, t);
		end
		if (tok_mode == MODE_AFTER) begin
			// A second quote right after a closing one is a literal quote.
			if (b == cfg_quote) begin
				tok_mode = MODE_QUOTED;
				return keep_byte(b, t);
			end
			tok_mode = MODE_PLAIN;
		end
		// Plain handling; when special bytes clash, delimiter wins over quote, and quote
		// wins over newline.
		if (b == cfg_delim) begin
			t = close_field(1'b0);
			return 1'b1;
		end
		if (b == cfg_quote) begin
			tok_mode = MODE_QUOTED;
			return 1'b0;
		end
		if (b == cfg_newline) begin
			t = close_field(1'b1);
			return 1'b1;
		end
		return keep_byte(b, t);
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Sender. A new beat is put up only once the previous one has been taken, and valid
	// is never dropped while a beat waits for ready.
	always @(negedge clk) begin : send_beats
		logic [8:0] beat;
		if (!in_valid || in_taken) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (beats_to_send.size() != 0) begin
				beat      = beats_to_send.pop_front();
				in_valid  <= 1'b1;
				kind      <= beat[8];
				data_byte <= beat[7:0];
				send_gap  <= calm ? 0 : idle_length();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver. Ready drops for stalls of random length, except in calm stretches.
	always @(negedge clk) begin : take_results
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left <= idle_length();
		end
	end

	// Rising edge: check the result beat against the oldest token, then follow register
	// writes and accepted input beats in the predictor. A result never comes out in the
	// same cycle as its input beat, so checking first is safe.
	always @(posedge clk) begin : watch_ports
		token_t want;
		token_t made;
		in_taken  <= in_valid && in_ready;
		cfg_taken <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (tokens_due.size() == 0) begin
					$error("result beat arrived with no token expected");
					errors++;
				end else begin
					want = tokens_due.pop_front();
					check_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
					check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
					check_field("field_end", 32'(want.field_end), 32'(field_end));
					check_field("record_end", 32'(want.record_end), 32'(record_end));
					check_field("field_length", 32'(want.field_length),
						32'(field_length));
					check_field("column_count", 32'(want.column_count),
						32'(column_count));
					check_field("record_index", 32'(want.record_index),
						32'(record_index));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELIMITER: cfg_delim   = cfg_data[BYTE_W-1:0];
					REG_QUOTE:     cfg_quote   = cfg_data[BYTE_W-1:0];
					REG_NEWLINE:   cfg_newline = cfg_data[BYTE_W-1:0];
					REG_MAX_LEN:   cfg_max_len = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (tokenize(kind, data_byte, made))
					tokens_due.push_back(made);
			end
		end
	end

	// Watchdog: a run that stops moving beats for too long has hung.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic put(input logic is_end, input logic [BYTE_W-1:0] b);
		beats_to_send.push_back({is_end, b});
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(1'b0, s[i]);
	endtask

	// One register write beat on the configuration channel.
	task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [CFG_D_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data  <= value;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued beat is sent and every token has come back, then lets the
	// block finish any beat that gives no result before the registers may change. The
	// check runs just after the falling edge, once the drivers have settled.
	task automatic settle();
		do begin
			@(negedge clk);
			#1;
		end while (beats_to_send.size() != 0 || in_valid || tokens_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// A content byte that none of the special bytes can be mistaken for.
	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (b == cfg_delim || b == cfg_quote || b == cfg_newline);
		return b;
	endfunction

	// Picks new special bytes and a new length limit. Unless clashes are allowed, the
	// three special bytes stay distinct.
	task automatic random_config(input bit allow_clash);
		logic [BYTE_W-1:0] d;
		logic [BYTE_W-1:0] q;
		logic [BYTE_W-1:0] n;
		logic [LEN_W-1:0]  m;
		case ($urandom_range(0, 4))
			0:       d = RST_DELIMITER;
			1:       d = 8'd9;
			2:       d = 8'd59;
			3:       d = 8'd0;
			default: d = BYTE_W'($urandom_range(0, 255));
		endcase
		do begin
			case ($urandom_range(0, 3))
				0:       q = RST_QUOTE;
				1:       q = 8'd39;
				2:       q = 8'd255;
				default: q = BYTE_W'($urandom_range(0, 255));
			endcase
		end while (!allow_clash && q == d);
		do begin
			case ($urandom_range(0, 2))
				0:       n = RST_NEWLINE;
				1:       n = 8'd13;
				default: n = BYTE_W'($urandom_range(0, 255));
			endcase
		end while (!allow_clash && (n == d || n == q));
		case ($urandom_range(0, 7))
			0:       m = '0;
			1:       m = LEN_W'($urandom_range(1, 3));
			2:       m = LEN_W'($urandom_range(4, 8));
			3:       m = 10'd1023;
			4:       m = LEN_W'($urandom_range(0, 1023));
			default: m = RST_MAX_LEN;
		endcase
		write_reg(REG_DELIMITER, {2'b00, d});
		write_reg(REG_QUOTE, {2'b00, q});
		write_reg(REG_NEWLINE, {2'b00, n});
		write_reg(REG_MAX_LEN, m);
	endtask

	// Random traffic: mostly well-formed records of plain and quoted fields with random
	// content, now and then closed by end of input, mixed with short bursts of noise
	// that lean toward the special bytes and end-of-input marks.
	task automatic random_records(input int count);
		int sent;
		int fields;
		int len;
		logic [BYTE_W-1:0] b;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 80) begin
				fields = $urandom_range(1, 4);
				for (int f = 0; f < fields; f++) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
						: $urandom_range(0, 5);
					if ($urandom_range(0, 1)) begin
						// Quoted field: any byte goes, and a quote inside is doubled.
						put(1'b0, cfg_quote);
						sent++;
						for (int i = 0; i < len; i++) begin
							b = BYTE_W'($urandom_range(0, 255));
							put(1'b0, b);
							sent++;
							if (b == cfg_quote) begin
								put(1'b0, b);
								sent++;
							end
						end
						put(1'b0, cfg_quote);
						sent++;
					end else begin
						for (int i = 0; i < len; i++) begin
							put(1'b0, plain_byte());
							sent++;
						end
					end
					if (f != fields - 1) begin
						put(1'b0, cfg_delim);
						sent++;
					end
				end
				if ($urandom_range(0, 9) == 0)
					put(1'b1, BYTE_W'($urandom_range(0, 255)));
				else
					put(1'b0, cfg_newline);
				sent++;
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 7))
						0:       put(1'b1, BYTE_W'($urandom_range(0, 255)));
						1:       put(1'b0, cfg_delim);
						2, 3:    put(1'b0, cfg_quote);
						4:       put(1'b0, cfg_newline);
						default: put(1'b0, BYTE_W'($urandom_range(0, 255)));
					endcase
					sent++;
				end
			end
		end
	endtask

	initial begin : stimulus
		// Reset is held from the start and released on a falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset configuration: plain bytes, a delimiter, a quoted field that holds a
		// delimiter and a newline, a doubled quote, content right after a closing quote,
		// and a newline that closes the record. Then an unterminated quote flushed by end
		// of input, and a second end of input with nothing pending.
		put_text("ab,\"x,\n\"\"y\"z\n");
		put_text("\"q");
		put(1'b1, 8'hFF);
		put(1'b1, 8'h00);
		settle();

		// All three special bytes equal: the delimiter test comes first.
		write_reg(REG_DELIMITER, 10'd34);
		write_reg(REG_NEWLINE, 10'd34);
		put_text("\"a");
		put(1'b1, 8'h00);
		settle();

		// Quote equal to newline: the quote wins. The closing quote is followed by a
		// delimiter, so end of input then flushes an empty field of a started record.
		write_reg(REG_DELIMITER, {2'b00, RST_DELIMITER});
		write_reg(REG_QUOTE, 10'd10);
		write_reg(REG_NEWLINE, 10'd10);
		put_text("\na\n,");
		put(1'b1, 8'h00);
		settle();

		// A short length limit drops the bytes past it.
		write_reg(REG_QUOTE, {2'b00, RST_QUOTE});
		write_reg(REG_NEWLINE, {2'b00, RST_NEWLINE});
		write_reg(REG_MAX_LEN, 10'd2);
		put_text("abc,\n");
		settle();

		// More delimiters than MAX_COLUMNS allows for: the column count saturates.
		write_reg(REG_MAX_LEN, RST_MAX_LEN);
		repeat (258) put(1'b0, RST_DELIMITER);
		put(1'b0, RST_NEWLINE);
		settle();

		// Special bytes at the ends and in the middle of their range.
		write_reg(REG_DELIMITER, 10'd255);
		write_reg(REG_QUOTE, 10'd0);
		write_reg(REG_NEWLINE, 10'd128);
		random_records(40);
		settle();

		// Random phases, each behind a fresh configuration; one of them without idling
		// and some with clashing special bytes. The drain between phases also makes the
		// sender wait until every expected token has come back.
		for (int p = 0; p < 8; p++) begin
			calm = (p == 3);
			random_config(p % 3 == 2);
			random_records(20);
			settle();
		end
		calm = 1'b0;

		// The block holds each result in its single result register, so the wait below is
		// plenty for any stray result beat to show up.
		repeat (8) @(posedge clk);
		if (tokens_due.size() != 0) begin
			$error("%0d expected tokens never arrived", tokens_due.size());
			errors++;
		end
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
sv/csvt_pkg.sv
sv/csvt_step.sv
sv/csv_field_tokenizer.sv
verif/testbench.sv
